// ===== rtl/core/erlt_pkg.sv =====
// ----------------------------------------------------------------------------
// Event rate limiter package
// Shared sizes, word types, drop reason codes and saturating helpers.
// ----------------------------------------------------------------------------
package erlt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int DAY_LENGTH    = 86400;
	localparam int HOUR_LENGTH   = 3600;
	localparam int HOURS_PER_DAY = 24;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ID_W   = 30;
	localparam int CNT_W  = 16;
	localparam int TIME_W = 32;

	// Reciprocal of the hours per day, scaled by two to the RECIP_SHIFT.
	localparam int RECIP_SHIFT = 31;
	localparam logic [31:0] HOUR_RECIP =
		32'(((64'd1 << RECIP_SHIFT) + 64'(HOURS_PER_DAY) - 64'd1) / 64'(HOURS_PER_DAY));

	localparam logic [1:0] REASON_NONE   = 2'd0;
	localparam logic [1:0] REASON_QUOTA  = 2'd1;
	localparam logic [1:0] REASON_PUNISH = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   evt_code;
		logic [TIME_W-1:0] happen_time;
		logic [TIME_W-1:0] now_time;
		logic [CNT_W-1:0]  daily_quota;
		logic [CNT_W-1:0]  log_spacing;
	} in_word_t;

	typedef struct packed {
		logic       dropped;
		logic [1:0] drop_reason;
		logic       skip_log;
		logic       untracked;
		logic       new_day;
	} out_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   key;
		logic [CNT_W-1:0]  daily_count;
		logic [CNT_W-1:0]  hour_count;
		logic [TIME_W-1:0] window_expiry;
		logic [CNT_W-1:0]  over_count;
		logic [TIME_W-1:0] last_time;
		logic [TIME_W-1:0] last_log;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] t,
			input logic [TIME_W-1:0] d);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {1'b0, d};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

// ===== rtl/core/erlt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module erlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/core/event_rate_limiter_table.sv =====
// A new-day word goes straight from ST_IDLE to ST_DONE; any other word first
// scans the whole table through the one RAM read port (ST_SCAN, ST_RESOLVE),
// and when the punish check runs it also passes ST_MUL_HALF, ST_MUL_LIMIT,
// ST_MUL_CHECK and ST_DECIDE. One word is in work at a time: no new word is
// taken until the last result has gone from ST_DONE to the output register. Reset
// clears the day start, all valid bits and the control state.
// ----------------------------------------------------------------------------
// Event rate limiter table
// Per-id rate limiter with a daily quota, hourly window, punish interval and
// log throttling, built around a table RAM scan and one shared multiplier.
// ----------------------------------------------------------------------------
module event_rate_limiter_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  erlt_pkg::in_word_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output erlt_pkg::out_word_t         out_data,
	input  logic                        cfg_wr_en,
	input  logic [erlt_pkg::TIME_W-1:0] cfg_wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_MUL_HALF,
		ST_MUL_LIMIT,
		ST_MUL_CHECK,
		ST_DECIDE,
		ST_DONE
	} state_t;

	state_t state_q;

	// The word in work and the day start register.
	erlt_pkg::in_word_t             item_q;
	logic [erlt_pkg::TIME_W-1:0]    day_start_q;

	// Valid bits live in flip-flops so a new day clears the table at once.
	logic                           valid_q [erlt_pkg::TABLE_ENTRIES];

	// Scan pointer is one bit wider so it can hold the entry count.
	logic [erlt_pkg::IDX_W:0]       idx_q;
	logic                           cmp_v_s1;
	logic [erlt_pkg::IDX_W-1:0]     cmp_idx_s1;
	logic                           hit_q;
	logic [erlt_pkg::IDX_W-1:0]     hit_idx_q;
	logic                           free_q;
	logic [erlt_pkg::IDX_W-1:0]     free_idx_q;
	erlt_pkg::entry_t               ent_q;

	// Shared multiplier and its result registers.
	logic [32:0]                    mul_a;
	logic [31:0]                    mul_b;
	logic [64:0]                    mul_p;
	logic [64:0]                    prod_q;
	logic [64:0]                    limit_q;
	logic                           over_half_q;

	// Table write port, registered.
	logic                           wr_en_q;
	logic [erlt_pkg::IDX_W-1:0]     wr_addr_q;
	erlt_pkg::entry_t               wr_data_q;
	logic [erlt_pkg::ENTRY_W-1:0]   rd_data;
	erlt_pkg::entry_t               rd_ent;

	erlt_pkg::out_word_t            res_q;
	erlt_pkg::out_word_t            out_data_q;
	logic                           out_valid_q;

	// Derived values of the word in work.
	logic [erlt_pkg::TIME_W:0]      day_end;
	logic [erlt_pkg::TIME_W:0]      in_day_end;
	logic [erlt_pkg::TIME_W:0]      left_time;
	logic [erlt_pkg::CNT_W-1:0]     rem;
	logic [16:0]                    half;
	logic [16:0]                    h_ext;
	logic [erlt_pkg::CNT_W-1:0]     h_next;
	logic [erlt_pkg::TIME_W-1:0]    gap;
	logic                           punish;

	assign rd_ent = erlt_pkg::entry_t'(rd_data);

	erlt_ram #(
		.WIDTH(erlt_pkg::ENTRY_W),
		.DEPTH(erlt_pkg::TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en_q),
		.wr_addr (wr_addr_q),
		.wr_data (wr_data_q),
		.rd_addr (idx_q[erlt_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// Day end is held one bit wider so it never wraps.
	assign day_end    = {1'b0, day_start_q} + 33'(erlt_pkg::DAY_LENGTH);
	assign in_day_end = day_end;
	assign left_time  = day_end - {1'b0, item_q.happen_time};
	assign rem        = item_q.daily_quota - ent_q.daily_count;
	assign half       = 17'((18'(prod_q[erlt_pkg::RECIP_SHIFT +: 17]) + 18'd1) >> 1);
	assign h_next     = erlt_pkg::cnt_inc(ent_q.hour_count);
	assign h_ext      = {1'b0, h_next};
	assign gap        = item_q.happen_time - ent_q.last_time;

	// The punish interval floor(P / rem) exceeds the gap exactly when
	// (gap + 1) * rem does not exceed P, so no divider is needed.
	assign punish = over_half_q && (item_q.happen_time >= ent_q.last_time) &&
		(prod_q <= limit_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_HALF: begin
				mul_a = 33'(rem) + 33'(erlt_pkg::HOURS_PER_DAY - 1);
				mul_b = erlt_pkg::HOUR_RECIP;
			end
			ST_MUL_LIMIT: begin
				mul_a = left_time;
				mul_b = 32'(h_ext - half);
			end
			ST_MUL_CHECK: begin
				mul_a = {1'b0, gap} + 33'd1;
				mul_b = 32'(rem);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 65'(mul_a) * 65'(mul_b);

	// Fresh entry for an inserted id.
	function automatic erlt_pkg::entry_t fill_entry(input erlt_pkg::in_word_t it);
		erlt_pkg::entry_t e;
		e.key           = it.evt_code;
		e.daily_count   = 16'd1;
		e.hour_count    = 16'd1;
		e.over_count    = '0;
		e.window_expiry = erlt_pkg::time_add(it.happen_time,
			32'(erlt_pkg::HOUR_LENGTH));
		e.last_time     = it.happen_time;
		e.last_log      = it.now_time;
		return e;
	endfunction

	// A log capture is skipped when the last one is too recent.
	function automatic logic log_skip(input erlt_pkg::entry_t e,
			input erlt_pkg::in_word_t it);
		logic [erlt_pkg::TIME_W-1:0] d;
		d = it.happen_time - e.last_log;
		return (it.happen_time >= e.last_log) && (d < 32'(it.log_spacing));
	endfunction

	// Bookkeeping for a kept event of a known id.
	function automatic erlt_pkg::entry_t keep_entry(input erlt_pkg::entry_t e,
			input erlt_pkg::in_word_t it);
		erlt_pkg::entry_t r;
		r             = e;
		r.last_time   = it.happen_time;
		r.daily_count = erlt_pkg::cnt_inc(e.daily_count);
		if (!log_skip(e, it)) begin
			r.last_log = it.now_time;
		end
		return r;
	endfunction

	// Over the daily quota the event is dropped but still counted.
	function automatic erlt_pkg::entry_t quota_entry(input erlt_pkg::entry_t e);
		erlt_pkg::entry_t r;
		r             = e;
		r.over_count  = erlt_pkg::cnt_inc(e.over_count);
		r.daily_count = erlt_pkg::cnt_inc(e.daily_count);
		return r;
	endfunction

	// A punished event only bumps the over count.
	function automatic erlt_pkg::entry_t punish_entry(input erlt_pkg::entry_t e);
		erlt_pkg::entry_t r;
		r            = e;
		r.over_count = erlt_pkg::cnt_inc(e.over_count);
		return r;
	endfunction

	// A kept event after the hourly window ran out opens the next window.
	function automatic erlt_pkg::entry_t window_entry(input erlt_pkg::entry_t e,
			input erlt_pkg::in_word_t it);
		erlt_pkg::entry_t r;
		r               = keep_entry(e, it);
		r.hour_count    = 16'd1;
		r.window_expiry = erlt_pkg::time_add(e.window_expiry,
			32'(erlt_pkg::HOUR_LENGTH));
		return r;
	endfunction

	// A kept event inside the window takes the next hour count.
	function automatic erlt_pkg::entry_t hour_entry(input erlt_pkg::entry_t e,
			input erlt_pkg::in_word_t it, input logic [erlt_pkg::CNT_W-1:0] h);
		erlt_pkg::entry_t r;
		r            = keep_entry(e, it);
		r.hour_count = h;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			day_start_q <= '0;
			for (int i = 0; i < erlt_pkg::TABLE_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
			idx_q       <= '0;
			cmp_v_s1    <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			wr_en_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_en_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				day_start_q <= cfg_wr_data;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q   <= in_data;
						idx_q    <= '0;
						cmp_v_s1 <= 1'b0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						if ({1'b0, in_data.happen_time} >= in_day_end) begin
							// A new day clears the table and takes entry zero.
							day_start_q <= in_data.happen_time;
							for (int i = 0; i < erlt_pkg::TABLE_ENTRIES; i++) begin
								valid_q[i] <= (i == 0);
							end
							wr_en_q   <= 1'b1;
							wr_addr_q <= '0;
							wr_data_q <= fill_entry(in_data);
							res_q     <= '{new_day: 1'b1, default: '0};
							state_q   <= ST_DONE;
						end else begin
							res_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end

				ST_SCAN: begin
					// Issue one read per cycle and compare the entry read last cycle.
					cmp_v_s1   <= (idx_q < (erlt_pkg::IDX_W + 1)'(erlt_pkg::TABLE_ENTRIES));
					cmp_idx_s1 <= idx_q[erlt_pkg::IDX_W-1:0];
					if (idx_q < (erlt_pkg::IDX_W + 1)'(erlt_pkg::TABLE_ENTRIES)) begin
						idx_q <= idx_q + 1'b1;
					end
					if (cmp_v_s1) begin
						if (valid_q[cmp_idx_s1]) begin
							if (!hit_q && rd_ent.key == item_q.evt_code) begin
								hit_q     <= 1'b1;
								hit_idx_q <= cmp_idx_s1;
								ent_q     <= rd_ent;
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
					end
					if (!cmp_v_s1 &&
							idx_q == (erlt_pkg::IDX_W + 1)'(erlt_pkg::TABLE_ENTRIES)) begin
						state_q <= ST_RESOLVE;
					end
				end

				ST_RESOLVE: begin
					if (!hit_q) begin
						if (free_q) begin
							valid_q[free_idx_q] <= 1'b1;
							wr_en_q             <= 1'b1;
							wr_addr_q           <= free_idx_q;
							wr_data_q           <= fill_entry(item_q);
						end else begin
							res_q <= '{untracked: 1'b1, default: '0};
						end
						state_q <= ST_DONE;
					end else if (ent_q.daily_count >= item_q.daily_quota) begin
						// Over the daily quota: dropped, but still counted.
						res_q     <= '{dropped: 1'b1, drop_reason: erlt_pkg::REASON_QUOTA,
							default: '0};
						wr_en_q   <= 1'b1;
						wr_addr_q <= hit_idx_q;
						wr_data_q <= quota_entry(ent_q);
						state_q   <= ST_DONE;
					end else if (ent_q.window_expiry <= item_q.happen_time) begin
						// Hourly window expired: open the next one and keep.
						wr_en_q   <= 1'b1;
						wr_addr_q <= hit_idx_q;
						wr_data_q <= window_entry(ent_q, item_q);
						res_q     <= '{skip_log: log_skip(ent_q, item_q), default: '0};
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_MUL_HALF;
					end
				end

				ST_MUL_HALF: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL_LIMIT;
				end

				ST_MUL_LIMIT: begin
					over_half_q <= h_ext > half;
					prod_q      <= mul_p;
					state_q     <= ST_MUL_CHECK;
				end

				ST_MUL_CHECK: begin
					limit_q <= prod_q;
					prod_q  <= mul_p;
					state_q <= ST_DECIDE;
				end

				ST_DECIDE: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= hit_idx_q;
					if (punish) begin
						res_q     <= '{dropped: 1'b1, drop_reason: erlt_pkg::REASON_PUNISH,
							default: '0};
						wr_data_q <= punish_entry(ent_q);
					end else begin
						wr_data_q <= hour_entry(ent_q, item_q, h_next);
						res_q     <= '{skip_log: log_skip(ent_q, item_q), default: '0};
					end
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					// Hand the result to the output register once it is free.
					if (!out_valid_q || out_ready) begin
						out_data_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/core/erlt_chk.sv =====
// ----------------------------------------------------------------------------
// Event rate limiter checker
// Port-level properties of the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module erlt_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input erlt_pkg::out_word_t out_data
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Dropped and the drop reason agree.
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.dropped == (out_data.drop_reason != erlt_pkg::REASON_NONE)))
		else $error("drop flag and reason disagree");

	// Only a kept event may skip its log capture.
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.skip_log |-> !out_data.dropped && !out_data.untracked
			&& !out_data.new_day)
		else $error("skip_log on a dropped, untracked or new-day word");

	// A new day always keeps and tracks its event.
	a_new_day: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.new_day |-> !out_data.dropped && !out_data.untracked)
		else $error("new-day word dropped or untracked");

	// Each word leaves ST_IDLE once taken, so input is not ready right after one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted word");

endmodule

bind event_rate_limiter_table erlt_chk u_erlt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
